@@ hdl/first_fit_page_allocator_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FFPA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffpa assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FFPA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffpa assertion failed");

`endif

@@ hdl/ffpa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffpa_pkg
// Shared field widths, codes and control bundles of the page allocator.
// ---------------------------------------------------------------------------
package ffpa_pkg;

	localparam int SIZE_W   = 13;
	localparam int ADDR_W   = 14;
	localparam int STATUS_W = 2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd3;

	typedef struct packed {
		logic gf_we;
		logic gf_wbit;
		logic bg_we;
	} mem_cmd_t;

	typedef struct packed {
		logic en;
		logic restart;
		logic inc;
	} run_ctl_t;

endpackage

@@ hdl/ffpa_if.sv @@
// ---------------------------------------------------------------------------
// ffpa_req_if / ffpa_rsp_if
// Valid/ready channels for allocator requests and responses.
// ---------------------------------------------------------------------------
interface ffpa_req_if import ffpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [SIZE_W-1:0] size;
	logic [ADDR_W-1:0] address;

	modport source (output valid, func, size, address, input ready);
	modport sink (input valid, func, size, address, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   block_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, block_address, status, input ready);
	modport sink (input valid, block_address, status, output ready);
endinterface

@@ hdl/ffpa_mem.sv @@
// ---------------------------------------------------------------------------
// ffpa_mem
// Granule free map and block length store, with a clearing sweep after reset.
// ---------------------------------------------------------------------------
module ffpa_mem import ffpa_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int NW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mem_cmd_t      cmd,
	input  logic [AW-1:0] gf_addr,
	input  logic [AW-1:0] bg_addr,
	input  logic [NW-1:0] bg_wdata,
	output logic          gf_rdata,
	output logic [NW-1:0] bg_rdata,
	output logic          init_busy
);

	logic          gf_mem [DEPTH];
	logic [NW-1:0] bg_mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;

	assign init_busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			gf_mem[clr_q] <= 1'b1;
		end else if (cmd.gf_we) begin
			gf_mem[gf_addr] <= cmd.gf_wbit;
		end
		gf_rdata <= gf_mem[gf_addr];
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			bg_mem[clr_q] <= '0;
		end else if (cmd.bg_we) begin
			bg_mem[bg_addr] <= bg_wdata;
		end
		bg_rdata <= bg_mem[bg_addr];
	end

endmodule

@@ hdl/ffpa_run.sv @@
// ---------------------------------------------------------------------------
// ffpa_run
// Shared run counter and limit compare: free-run length during the search,
// granule count during claim and release sweeps.
// ---------------------------------------------------------------------------
module ffpa_run import ffpa_pkg::*; #(
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  run_ctl_t         ctl,
	input  logic [CNT_W-1:0] limit,
	output logic             hit
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] base;
	logic [CNT_W:0]   nxt;

	assign base = ctl.restart ? '0 : count_q;
	assign nxt  = {1'b0, base} + (CNT_W+1)'(1);
	assign hit  = ctl.en && ctl.inc && (nxt >= {1'b0, limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.en) begin
			count_q <= ctl.inc ? nxt[CNT_W-1:0] : '0;
		end
	end

endmodule

@@ hdl/first_fit_page_allocator.sv @@
// Request accept to response valid: a bad size or bad free address goes straight to the
// response; an alloc opens the first page if none is open, else scans the open pages, then
// claims the first fit or a new page, or answers no space; a free reads and checks the
// block length, then releases its granules, or answers unknown where no block starts. One
// request in flight: ready returns in the cycle after the response register loads. Reset: a
// clearing sweep over all PAGE_COUNT * PAGE_BYTES / GRANULE_BYTES granules runs first.
// ---------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit granule allocator over fixed pages; freed runs merge in the map.
// Page and granule sizes must be powers of two; the block itself does not check this.
// ---------------------------------------------------------------------------
`include "first_fit_page_allocator_assert.svh"

module first_fit_page_allocator import ffpa_pkg::*; #(
	parameter int PAGE_BYTES    = 4096,
	parameter int GRANULE_BYTES = 256,
	parameter int PAGE_COUNT    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	ffpa_req_if.sink    req,
	ffpa_rsp_if.source  rsp
);

	localparam int GPP     = PAGE_BYTES / GRANULE_BYTES;
	localparam int TOTAL   = GPP * PAGE_COUNT;
	localparam int GA_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int GP_W    = (GPP > 1) ? $clog2(GPP) : 1;
	localparam int PC_W    = $clog2(PAGE_COUNT + 1);
	localparam int NW      = $clog2(GPP + 1);
	localparam int GB_W    = $clog2(GRANULE_BYTES);
	localparam int GPP_LOG = $clog2(GPP);

	localparam logic [2:0] S_INIT     = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_CLAIM    = 3'd3;
	localparam logic [2:0] S_FREE_RD  = 3'd4;
	localparam logic [2:0] S_FREE_CHK = 3'd5;
	localparam logic [2:0] S_FREE_WR  = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0]          state_q;
	logic [PC_W-1:0]     pages_q;
	logic [NW-1:0]       n_q;
	logic [GA_W-1:0]     hit_q;
	logic [GA_W-1:0]     w_q;
	logic                first_q;
	logic [GA_W-1:0]     iss_addr_q;
	logic [GP_W-1:0]     gip_q;
	logic [PC_W-1:0]     ip_q;
	logic                iss_done_q;
	logic                v_s1;
	logic                restart_s1;
	logic                last_s1;
	logic [GA_W-1:0]     idx_s1;
	logic [ADDR_W-1:0]   baddr_q;
	logic [STATUS_W-1:0] stat_q;
	logic                res_valid_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [STATUS_W-1:0] res_stat_q;

	mem_cmd_t        cmd;
	run_ctl_t        run_ctl;
	logic            run_hit;
	logic            gf_rdata;
	logic [NW-1:0]   bg_rdata;
	logic [NW-1:0]   bg_wdata;
	logic [GA_W-1:0] gf_addr;
	logic            init_busy;

	logic [31:0]     size32;
	logic [31:0]     addr32;
	logic [31:0]     n32;
	logic [31:0]     idx32;
	logic            size_bad;
	logic            free_bad;
	logic            last_issue;
	logic            scan_hit;
	logic            scan_miss;
	logic [31:0]     hit32;
	logic [31:0]     open32;
	logic [31:0]     ba32;

	assign size32   = 32'(req.size);
	assign addr32   = 32'(req.address);
	assign n32      = size32 >> GB_W;
	assign idx32    = addr32 >> GB_W;
	assign size_bad = (size32 == 32'd0) || ((size32 & 32'(GRANULE_BYTES - 1)) != 32'd0)
		|| (size32 > 32'(PAGE_BYTES));
	assign free_bad = ((addr32 & 32'(GRANULE_BYTES - 1)) != 32'd0) || (idx32 >= 32'(TOTAL));

	assign last_issue = (ip_q == PC_W'(pages_q - PC_W'(1))) && (gip_q == GP_W'(GPP - 1));
	assign scan_hit   = (state_q == S_SCAN) && v_s1 && run_hit;
	assign scan_miss  = (state_q == S_SCAN) && v_s1 && !run_hit && last_s1;
	assign hit32      = 32'(idx_s1) + 32'd1 - 32'(n_q);
	assign open32     = 32'(pages_q) << GPP_LOG;
	assign ba32       = 32'(hit_q) << GB_W;

	always_comb begin
		run_ctl = '0;
		cmd     = '0;
		case (state_q)
			S_SCAN: begin
				run_ctl.en      = v_s1;
				run_ctl.restart = restart_s1;
				run_ctl.inc     = gf_rdata;
			end
			S_CLAIM, S_FREE_WR: begin
				run_ctl.en      = 1'b1;
				run_ctl.restart = first_q;
				run_ctl.inc     = 1'b1;
				cmd.gf_we       = 1'b1;
				cmd.gf_wbit     = (state_q == S_FREE_WR);
				cmd.bg_we       = first_q;
			end
			default: begin
			end
		endcase
	end

	assign gf_addr  = (state_q == S_SCAN) ? iss_addr_q : w_q;
	assign bg_wdata = (state_q == S_CLAIM) ? n_q : '0;

	ffpa_mem #(
		.DEPTH (TOTAL),
		.AW    (GA_W),
		.NW    (NW)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.gf_addr   (gf_addr),
		.bg_addr   (hit_q),
		.bg_wdata  (bg_wdata),
		.gf_rdata  (gf_rdata),
		.bg_rdata  (bg_rdata),
		.init_busy (init_busy)
	);

	ffpa_run #(
		.CNT_W (NW)
	) u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (run_ctl),
		.limit  (n_q),
		.hit    (run_hit)
	);

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = res_valid_q;
	assign rsp.block_address = res_addr_q;
	assign rsp.status        = res_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			pages_q    <= '0;
			n_q        <= '0;
			hit_q      <= '0;
			w_q        <= '0;
			first_q    <= 1'b0;
			iss_addr_q <= '0;
			gip_q      <= '0;
			ip_q       <= '0;
			iss_done_q <= 1'b0;
			v_s1       <= 1'b0;
			restart_s1 <= 1'b0;
			last_s1    <= 1'b0;
			idx_s1     <= '0;
			baddr_q    <= '0;
			stat_q     <= ST_OK;
		end else begin
			case (state_q)
				S_INIT: begin
					if (!init_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						baddr_q <= '0;
						if (req.func == FUNC_FREE) begin
							if (free_bad) begin
								stat_q  <= ST_UNKNOWN;
								state_q <= S_DONE;
							end else begin
								hit_q   <= idx32[GA_W-1:0];
								state_q <= S_FREE_RD;
							end
						end else if (size_bad) begin
							stat_q  <= ST_BAD_SIZE;
							state_q <= S_DONE;
						end else begin
							n_q <= n32[NW-1:0];
							if (pages_q == '0) begin
								hit_q   <= '0;
								w_q     <= '0;
								pages_q <= PC_W'(1);
								first_q <= 1'b1;
								state_q <= S_CLAIM;
							end else begin
								iss_addr_q <= '0;
								gip_q      <= '0;
								ip_q       <= '0;
								iss_done_q <= 1'b0;
								v_s1       <= 1'b0;
								state_q    <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					v_s1       <= !iss_done_q && !scan_hit && !scan_miss;
					restart_s1 <= (gip_q == '0);
					last_s1    <= last_issue;
					idx_s1     <= iss_addr_q;
					if (!iss_done_q) begin
						iss_addr_q <= iss_addr_q + GA_W'(1);
						iss_done_q <= last_issue;
						if (gip_q == GP_W'(GPP - 1)) begin
							gip_q <= '0;
							ip_q  <= ip_q + PC_W'(1);
						end else begin
							gip_q <= gip_q + GP_W'(1);
						end
					end
					if (scan_hit) begin
						hit_q   <= hit32[GA_W-1:0];
						w_q     <= hit32[GA_W-1:0];
						first_q <= 1'b1;
						state_q <= S_CLAIM;
					end else if (scan_miss) begin
						if (pages_q == PC_W'(PAGE_COUNT)) begin
							stat_q  <= ST_NO_SPACE;
							state_q <= S_DONE;
						end else begin
							hit_q   <= open32[GA_W-1:0];
							w_q     <= open32[GA_W-1:0];
							pages_q <= pages_q + PC_W'(1);
							first_q <= 1'b1;
							state_q <= S_CLAIM;
						end
					end
				end
				S_CLAIM: begin
					w_q     <= w_q + GA_W'(1);
					first_q <= 1'b0;
					if (run_hit) begin
						baddr_q <= ba32[ADDR_W-1:0];
						stat_q  <= ST_OK;
						state_q <= S_DONE;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (bg_rdata == '0) begin
						stat_q  <= ST_UNKNOWN;
						state_q <= S_DONE;
					end else begin
						n_q     <= bg_rdata;
						w_q     <= hit_q;
						first_q <= 1'b1;
						state_q <= S_FREE_WR;
					end
				end
				S_FREE_WR: begin
					w_q     <= w_q + GA_W'(1);
					first_q <= 1'b0;
					if (run_hit) begin
						stat_q  <= ST_OK;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!res_valid_q || rsp.ready)) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!res_valid_q || rsp.ready)) begin
			res_addr_q <= baddr_q;
			res_stat_q <= stat_q;
		end
	end

	`FFPA_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	`FFPA_ASSERT_IMP(a_pages_bound, 1'b1, pages_q <= PC_W'(PAGE_COUNT))
	`FFPA_ASSERT_IMP(a_fail_addr_zero, rsp.valid && rsp.status != ST_OK, rsp.block_address == '0)
	`FFPA_ASSERT_IMP(a_no_accept_in_sweep, init_busy, !req.ready)

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for first_fit_page_allocator. A queue of planned
// requests feeds a bursty driver; a monitor predicts each accepted request
// against its own model of the free map and checks every response in order.
// ---------------------------------------------------------------------------
module testbench import ffpa_pkg::*; ();

	localparam int PAGE_BYTES     = 4096;
	localparam int GRANULE_BYTES  = 256;
	localparam int PAGE_COUNT     = 4;
	localparam int GRANS_PER_PAGE = PAGE_BYTES / GRANULE_BYTES;
	localparam int GRANULES       = GRANS_PER_PAGE * PAGE_COUNT;
	localparam int RANDOM_ITEMS   = 1426;
	localparam int LIMIT_CYCLES   = 1000000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic              func;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] address;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   block_address;
		logic [STATUS_W-1:0] status;
	} response_t;

	typedef struct packed {
		logic [GRANULES-1:0]      free_map;
		logic [GRANULES-1:0][4:0] blk_len;
		logic [2:0]               pages;
	} heap_t;

	logic clk;
	logic arst_n;

	ffpa_req_if req_ch ();
	ffpa_rsp_if rsp_ch ();

	first_fit_page_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	request_t    pending_q[$];
	response_t   expected_q[$];
	logic [ADDR_W-1:0] live_blocks[$];
	heap_t       plan_heap;
	heap_t       model_heap;
	logic        req_fire;
	int          accepted_count;
	int          mismatch_count;
	int          cycle_count;
	int          burst_left;
	int          gap_left;
	int          hold_left;
	int          holds_done;
	int          rdy_mode;
	int          rdy_mode_left;
	int          rdy_phase;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic heap_t empty_heap();
		heap_t h;
		h.free_map = '1;
		h.blk_len  = '0;
		h.pages    = '0;
		return h;
	endfunction

	// Applies one request to a heap image and returns the response it yields.
	function automatic void serve_request(inout heap_t h, input request_t r,
			output response_t o);
		int unsigned n;
		int unsigned run_len;
		int unsigned hit_g;
		int unsigned idx;
		int p;
		int g;
		bit hit;
		o.block_address = '0;
		o.status        = ST_OK;
		hit   = 1'b0;
		hit_g = 0;
		if (r.func == FUNC_ALLOC) begin
			if (r.size == 0 || (r.size % GRANULE_BYTES) != 0 || r.size > PAGE_BYTES) begin
				o.status = ST_BAD_SIZE;
				return;
			end
			n = r.size / GRANULE_BYTES;
			for (p = 0; p < h.pages && !hit; p++) begin
				run_len = 0;
				for (g = 0; g < GRANS_PER_PAGE && !hit; g++) begin
					if (h.free_map[p * GRANS_PER_PAGE + g]) begin
						run_len++;
						if (run_len >= n) begin
							hit   = 1'b1;
							hit_g = p * GRANS_PER_PAGE + g + 1 - n;
						end
					end else begin
						run_len = 0;
					end
				end
			end
			if (!hit) begin
				if (h.pages >= PAGE_COUNT) begin
					o.status = ST_NO_SPACE;
					return;
				end
				hit_g   = h.pages * GRANS_PER_PAGE;
				h.pages = h.pages + 1'b1;
			end
			for (g = 0; g < n; g++)
				h.free_map[hit_g + g] = 1'b0;
			h.blk_len[hit_g] = n[4:0];
			o.block_address  = ADDR_W'(hit_g * GRANULE_BYTES);
		end else begin
			idx = r.address / GRANULE_BYTES;
			if ((r.address % GRANULE_BYTES) != 0 || idx >= GRANULES || h.blk_len[idx] == 0) begin
				o.status = ST_UNKNOWN;
				return;
			end
			n = 32'(h.blk_len[idx]);
			for (g = 0; g < n && idx + g < GRANULES; g++)
				h.free_map[idx + g] = 1'b1;
			h.blk_len[idx] = '0;
		end
	endfunction

	// Plans a request and tracks which block starts are live at that point.
	function automatic void queue_request(logic func, int unsigned size,
			int unsigned address);
		request_t  r;
		response_t o;
		int i;
		r.func    = func;
		r.size    = SIZE_W'(size);
		r.address = ADDR_W'(address);
		serve_request(plan_heap, r, o);
		if (o.status == ST_OK) begin
			if (func == FUNC_ALLOC) begin
				live_blocks.insert(live_blocks.size(), o.block_address);
			end else begin
				for (i = 0; i < live_blocks.size(); i++) begin
					if (live_blocks[i] == r.address) begin
						live_blocks.delete(i);
						break;
					end
				end
			end
		end
		pending_q.insert(pending_q.size(), r);
	endfunction

	function automatic int unsigned pick_granules();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 4);
		else if (r < 95)
			return $urandom_range(5, 12);
		return $urandom_range(13, GRANS_PER_PAGE);
	endfunction

	task automatic plan_stimulus();
		int k;
		int unsigned r;
		int unsigned used;
		int unsigned pick;
		// size checks and unknown frees on an empty heap
		queue_request(FUNC_ALLOC, 0, 0);
		queue_request(FUNC_ALLOC, 1, 0);
		queue_request(FUNC_ALLOC, 255, 0);
		queue_request(FUNC_ALLOC, 4097, 0);
		queue_request(FUNC_ALLOC, 8191, 16383);
		queue_request(FUNC_ALLOC, 4352, 0);
		queue_request(FUNC_FREE, 0, 0);
		queue_request(FUNC_FREE, 8191, 16383);
		// page opening, reuse, double free, exhaustion
		queue_request(FUNC_ALLOC, 256, 0);
		queue_request(FUNC_ALLOC, 4096, 0);
		queue_request(FUNC_ALLOC, 512, 0);
		queue_request(FUNC_FREE, 0, 0);
		queue_request(FUNC_FREE, 0, 0);
		queue_request(FUNC_ALLOC, 256, 0);
		queue_request(FUNC_ALLOC, 4096, 0);
		queue_request(FUNC_ALLOC, 4096, 0);
		queue_request(FUNC_ALLOC, 4096, 0);
		queue_request(FUNC_FREE, 0, 12288);
		queue_request(FUNC_FREE, 0, 12544);
		queue_request(FUNC_ALLOC, 3840, 0);
		queue_request(FUNC_FREE, 0, 4096);
		queue_request(FUNC_ALLOC, 4096, 0);
		queue_request(FUNC_FREE, 8191, 256);
		queue_request(FUNC_ALLOC, 256, 16383);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			r    = $urandom_range(0, 99);
			used = $countones(~plan_heap.free_map);
			if (r < 6) begin
				pick = $urandom_range(0, 2);
				if (pick == 0)
					queue_request(FUNC_ALLOC, 0, $urandom_range(0, 16383));
				else if (pick == 1)
					queue_request(FUNC_ALLOC, $urandom_range(1, 8191), $urandom_range(0, 16383));
				else
					queue_request(FUNC_ALLOC, $urandom_range(17, 31) * GRANULE_BYTES,
						$urandom_range(0, 16383));
			end else if (r < 11) begin
				if ($urandom_range(0, 1) == 0)
					queue_request(FUNC_FREE, $urandom_range(0, 8191), $urandom_range(0, 16383));
				else
					queue_request(FUNC_FREE, $urandom_range(0, 8191),
						$urandom_range(0, GRANULES - 1) * GRANULE_BYTES);
			end else if (live_blocks.size() > 0 &&
					$urandom_range(0, 99) < ((used > 40) ? 60 : 35)) begin
				pick = $urandom_range(0, live_blocks.size() - 1);
				queue_request(FUNC_FREE, $urandom_range(0, 8191), live_blocks[pick]);
			end else begin
				queue_request(FUNC_ALLOC, pick_granules() * GRANULE_BYTES,
					$urandom_range(0, 16383));
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.func    = FUNC_ALLOC;
		req_ch.size    = '0;
		req_ch.address = '0;
		rsp_ch.ready   = 1'b0;
		req_fire       = 1'b0;
		accepted_count = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		burst_left     = 0;
		gap_left       = 0;
		hold_left      = 0;
		holds_done     = 0;
		rdy_mode       = 0;
		rdy_mode_left  = 0;
		rdy_phase      = 0;
		plan_heap      = empty_heap();
		model_heap     = empty_heap();
		plan_stimulus();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS first_fit_page_allocator");
		else
			$display("FAIL first_fit_page_allocator");
		$finish;
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL first_fit_page_allocator");
			$finish;
		end
	end

	always @(negedge clk) begin : driver
		logic     next_valid;
		request_t next_item;
		if (arst_n && (!req_ch.valid || req_fire)) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
			end else if (pending_q.size() > 0) begin
				next_item  = pending_q.pop_front();
				next_valid = 1'b1;
				{req_ch.func, req_ch.size, req_ch.address} <= next_item;
				if (burst_left > 0)
					burst_left = burst_left - 1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			req_ch.valid <= next_valid;
		end
	end

	always @(negedge clk) begin : receiver
		logic rdy;
		if (rdy_mode_left == 0) begin
			rdy_mode      = $urandom_range(0, 2);
			rdy_mode_left = $urandom_range(20, 200);
		end
		rdy_mode_left = rdy_mode_left - 1;
		rdy_phase     = (rdy_phase + 1) % 3;
		case (rdy_mode)
			0: rdy = 1'b1;
			1: rdy = (rdy_phase == 0);
			default: rdy = 1'($urandom_range(0, 1));
		endcase
		rsp_ch.ready <= rdy && (hold_left == 0);
	end

	// long receiver hold-off so the request side backs up
	always @(posedge clk) begin : hold_off
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && accepted_count >= (holds_done + 1) * 500) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk) begin : monitor
		request_t  item;
		response_t want;
		response_t got;
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.block_address = rsp_ch.block_address;
			got.status        = rsp_ch.status;
			if (expected_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected response: addr %0d status %0d",
						got.block_address, got.status);
				mismatch_count = mismatch_count + 1;
			end else begin
				want = expected_q.pop_front();
				if (got.block_address !== want.block_address || got.status !== want.status) begin
					if (mismatch_count < 10)
						$display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
							want.block_address, want.status, got.block_address, got.status);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			item.func    = req_ch.func;
			item.size    = req_ch.size;
			item.address = req_ch.address;
			serve_request(model_heap, item, want);
			expected_q.insert(expected_q.size(), want);
			accepted_count <= accepted_count + 1;
		end
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ffpa_pkg.sv
hdl/ffpa_if.sv
hdl/ffpa_mem.sv
hdl/ffpa_run.sv
hdl/first_fit_page_allocator.sv
bench/testbench.sv
